// File: hw/rtl/mhpq_pkg.sv
package mhpq_pkg;

  // Heap geometry.
  localparam int unsigned CAPACITY = 16;
  localparam int unsigned IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned CIDX_W   = IDX_W + 2;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned TOTAL_W  = 5;
  localparam int unsigned STAT_W   = 2;

  // Microprogram store geometry.
  localparam int unsigned UPC_W = 5;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  // Request codes.
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  // Datapath operations, one per microinstruction.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_INS_START,
    OP_RD_PARENT,
    OP_MOVE_UP,
    OP_WRITE_KEY,
    OP_REM_START,
    OP_LOAD_KEY,
    OP_RD_LEFT,
    OP_TAKE_LEFT,
    OP_TAKE_RIGHT,
    OP_MOVE_DOWN,
    OP_CLEAR,
    OP_FIN_DONE,
    OP_FIN_FULL,
    OP_FIN_EMPTY
  } op_e;

  // Jump conditions.
  typedef enum logic [3:0] {
    C_NONE,
    C_ALWAYS,
    C_NO_ITEM,
    C_IS_REMOVE,
    C_FULL,
    C_EMPTY,
    C_ONE,
    C_AT_ROOT,
    C_PARENT_NOT_LESS,
    C_NO_LEFT,
    C_NO_RIGHT,
    C_CHILD_NOT_BIGGER
  } cond_e;

  typedef struct packed {
    op_e              op;
    cond_e            cond;
    logic [UPC_W-1:0] tgt;
  } uword_t;

  // Control from the sequencer to the datapath.
  typedef struct packed {
    op_e op;
  } ctrl_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic item_valid;
    logic out_busy;
    logic is_remove;
    logic full;
    logic empty;
    logic one;
    logic at_root;
    logic parent_not_less;
    logic no_left;
    logic no_right;
    logic child_not_bigger;
  } flags_t;

  // Microprogram entry points.
  localparam logic [UPC_W-1:0] A_IDLE     = UPC_W'(0);
  localparam logic [UPC_W-1:0] A_DISPATCH = UPC_W'(1);
  localparam logic [UPC_W-1:0] A_INS_CHK  = UPC_W'(2);
  localparam logic [UPC_W-1:0] A_INS      = UPC_W'(3);
  localparam logic [UPC_W-1:0] A_UP_LOOP  = UPC_W'(4);
  localparam logic [UPC_W-1:0] A_UP_CMP   = UPC_W'(5);
  localparam logic [UPC_W-1:0] A_UP_MOVE  = UPC_W'(6);
  localparam logic [UPC_W-1:0] A_PLACE    = UPC_W'(7);
  localparam logic [UPC_W-1:0] A_FIN      = UPC_W'(8);
  localparam logic [UPC_W-1:0] A_FULL     = UPC_W'(9);
  localparam logic [UPC_W-1:0] A_REM      = UPC_W'(10);
  localparam logic [UPC_W-1:0] A_REM_CHK  = UPC_W'(11);
  localparam logic [UPC_W-1:0] A_REM_GO   = UPC_W'(12);
  localparam logic [UPC_W-1:0] A_REM_LOAD = UPC_W'(13);
  localparam logic [UPC_W-1:0] A_DN_LOOP  = UPC_W'(14);
  localparam logic [UPC_W-1:0] A_DN_LEFT  = UPC_W'(15);
  localparam logic [UPC_W-1:0] A_DN_RIGHT = UPC_W'(16);
  localparam logic [UPC_W-1:0] A_DN_CMP   = UPC_W'(17);
  localparam logic [UPC_W-1:0] A_DN_MOVE  = UPC_W'(18);
  localparam logic [UPC_W-1:0] A_ONE      = UPC_W'(19);
  localparam logic [UPC_W-1:0] A_EMPTY    = UPC_W'(20);

  // The microprogram itself. A step runs its operation, then jumps to its
  // target when its condition holds and otherwise falls through.
  function automatic uword_t ucode_rom(input logic [UPC_W-1:0] addr);
    uword_t w;
    w = '{op: OP_NOP, cond: C_ALWAYS, tgt: A_IDLE};
    case (addr)
      A_IDLE:     w = '{op: OP_ACCEPT,     cond: C_NO_ITEM,          tgt: A_IDLE};
      A_DISPATCH: w = '{op: OP_NOP,        cond: C_IS_REMOVE,        tgt: A_REM};
      A_INS_CHK:  w = '{op: OP_NOP,        cond: C_FULL,             tgt: A_FULL};
      A_INS:      w = '{op: OP_INS_START,  cond: C_NONE,             tgt: A_IDLE};
      A_UP_LOOP:  w = '{op: OP_RD_PARENT,  cond: C_AT_ROOT,          tgt: A_PLACE};
      A_UP_CMP:   w = '{op: OP_NOP,        cond: C_PARENT_NOT_LESS,  tgt: A_PLACE};
      A_UP_MOVE:  w = '{op: OP_MOVE_UP,    cond: C_ALWAYS,           tgt: A_UP_LOOP};
      A_PLACE:    w = '{op: OP_WRITE_KEY,  cond: C_NONE,             tgt: A_IDLE};
      A_FIN:      w = '{op: OP_FIN_DONE,   cond: C_ALWAYS,           tgt: A_IDLE};
      A_FULL:     w = '{op: OP_FIN_FULL,   cond: C_ALWAYS,           tgt: A_IDLE};
      A_REM:      w = '{op: OP_NOP,        cond: C_EMPTY,            tgt: A_EMPTY};
      A_REM_CHK:  w = '{op: OP_NOP,        cond: C_ONE,              tgt: A_ONE};
      A_REM_GO:   w = '{op: OP_REM_START,  cond: C_NONE,             tgt: A_IDLE};
      A_REM_LOAD: w = '{op: OP_LOAD_KEY,   cond: C_NONE,             tgt: A_IDLE};
      A_DN_LOOP:  w = '{op: OP_RD_LEFT,    cond: C_NO_LEFT,          tgt: A_PLACE};
      A_DN_LEFT:  w = '{op: OP_TAKE_LEFT,  cond: C_NO_RIGHT,         tgt: A_DN_CMP};
      A_DN_RIGHT: w = '{op: OP_TAKE_RIGHT, cond: C_NONE,             tgt: A_IDLE};
      A_DN_CMP:   w = '{op: OP_NOP,        cond: C_CHILD_NOT_BIGGER, tgt: A_PLACE};
      A_DN_MOVE:  w = '{op: OP_MOVE_DOWN,  cond: C_ALWAYS,           tgt: A_DN_LOOP};
      A_ONE:      w = '{op: OP_CLEAR,      cond: C_ALWAYS,           tgt: A_FIN};
      A_EMPTY:    w = '{op: OP_FIN_EMPTY,  cond: C_ALWAYS,           tgt: A_IDLE};
      default:    w = '{op: OP_NOP,        cond: C_ALWAYS,           tgt: A_IDLE};
    endcase
    return w;
  endfunction

endpackage

// File: hw/rtl/mhpq_seq.sv
module mhpq_seq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mhpq_pkg::flags_t flags_i,
  output mhpq_pkg::ctrl_t  ctrl_o
);

  logic [mhpq_pkg::UPC_W-1:0] upc_d, upc_q;
  mhpq_pkg::uword_t           word;
  logic                       stall;
  logic                       taken;

  // Fetch the current microinstruction.
  assign word = mhpq_pkg::ucode_rom(upc_q);

  // A finishing step waits while the previous result is still unread.
  assign stall = flags_i.out_busy &&
                 ((word.op == mhpq_pkg::OP_FIN_DONE) ||
                  (word.op == mhpq_pkg::OP_FIN_FULL) ||
                  (word.op == mhpq_pkg::OP_FIN_EMPTY));

  // Evaluate the jump condition.
  always_comb begin
    case (word.cond)
      mhpq_pkg::C_NONE:             taken = 1'b0;
      mhpq_pkg::C_ALWAYS:           taken = 1'b1;
      mhpq_pkg::C_NO_ITEM:          taken = !flags_i.item_valid;
      mhpq_pkg::C_IS_REMOVE:        taken = flags_i.is_remove;
      mhpq_pkg::C_FULL:             taken = flags_i.full;
      mhpq_pkg::C_EMPTY:            taken = flags_i.empty;
      mhpq_pkg::C_ONE:              taken = flags_i.one;
      mhpq_pkg::C_AT_ROOT:          taken = flags_i.at_root;
      mhpq_pkg::C_PARENT_NOT_LESS:  taken = flags_i.parent_not_less;
      mhpq_pkg::C_NO_LEFT:          taken = flags_i.no_left;
      mhpq_pkg::C_NO_RIGHT:         taken = flags_i.no_right;
      mhpq_pkg::C_CHILD_NOT_BIGGER: taken = flags_i.child_not_bigger;
      default:                      taken = 1'b0;
    endcase
  end

  // Next step: hold, jump or fall through.
  always_comb begin
    if (stall) begin
      upc_d = upc_q;
    end else if (taken) begin
      upc_d = word.tgt;
    end else begin
      upc_d = upc_q + mhpq_pkg::UPC_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= mhpq_pkg::A_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

  // A stalled step issues no operation.
  assign ctrl_o.op = stall ? mhpq_pkg::OP_NOP : word.op;

  // The step counter only ever leaves the idle step with an item waiting.
  a_idle_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upc_q == mhpq_pkg::A_IDLE) && !flags_i.item_valid |=> (upc_q == mhpq_pkg::A_IDLE))
    else $error("sequencer left idle without an item");

  // A stall holds the step counter.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall |=> $stable(upc_q))
    else $error("step counter moved during a stall");

endmodule

// File: hw/rtl/mhpq_dp.sv
module mhpq_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mhpq_pkg::ctrl_t                   ctrl_i,
  output mhpq_pkg::flags_t                  flags_o,
  input  logic                              in_valid_i,
  input  logic                              req_type_i,
  input  logic signed [mhpq_pkg::KEY_W-1:0] key_value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [mhpq_pkg::STAT_W-1:0]       status_o,
  output logic [mhpq_pkg::TOTAL_W-1:0]      entry_total_o,
  output logic                              top_valid_o,
  output logic signed [mhpq_pkg::KEY_W-1:0] top_key_o
);

  localparam int unsigned IW = mhpq_pkg::IDX_W;
  localparam int unsigned CW = mhpq_pkg::CNT_W;
  localparam int unsigned XW = mhpq_pkg::CIDX_W;
  localparam int unsigned KW = mhpq_pkg::KEY_W;

  // Key store.
  logic signed [KW-1:0] mem [mhpq_pkg::CAPACITY];

  logic [CW-1:0]        cnt_q;
  logic [IW-1:0]        pos_q;
  logic [IW-1:0]        cidx_q;
  logic                 req_q;
  logic signed [KW-1:0] key_q;
  logic signed [KW-1:0] cand_q;
  logic signed [KW-1:0] rdata_q;
  logic signed [KW-1:0] top_q;

  logic                       out_valid_q;
  logic [mhpq_pkg::STAT_W-1:0] status_q;
  logic [mhpq_pkg::TOTAL_W-1:0] total_q;
  logic                       topv_q;
  logic signed [KW-1:0]       topk_q;

  logic [IW-1:0]        parent_idx;
  logic [XW-1:0]        left_x, right_x;
  logic [IW-1:0]        raddr;
  logic                 re;
  logic                 we;
  logic signed [KW-1:0] wdata;
  logic                 fin;
  logic [mhpq_pkg::STAT_W-1:0] fin_status;

  // Index arithmetic around the current hole.
  assign parent_idx = (pos_q - IW'(1)) >> 1;
  assign left_x     = {XW'(pos_q) << 1} + XW'(1);
  assign right_x    = {XW'(pos_q) << 1} + XW'(2);

  // Read port address select.
  always_comb begin
    re    = 1'b1;
    raddr = parent_idx;
    case (ctrl_i.op)
      mhpq_pkg::OP_RD_PARENT: raddr = parent_idx;
      mhpq_pkg::OP_REM_START: raddr = IW'(cnt_q - CW'(1));
      mhpq_pkg::OP_RD_LEFT:   raddr = left_x[IW-1:0];
      mhpq_pkg::OP_TAKE_LEFT: raddr = right_x[IW-1:0];
      default:                re    = 1'b0;
    endcase
  end

  // Write port select.
  always_comb begin
    we    = 1'b1;
    wdata = key_q;
    case (ctrl_i.op)
      mhpq_pkg::OP_WRITE_KEY: wdata = key_q;
      mhpq_pkg::OP_MOVE_UP:   wdata = rdata_q;
      mhpq_pkg::OP_MOVE_DOWN: wdata = cand_q;
      default:                we    = 1'b0;
    endcase
  end

  // Store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[pos_q] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  // Shadow of the root entry, kept in step with every write to it.
  always_ff @(posedge clk_i) begin
    if (we && (pos_q == '0)) begin
      top_q <= wdata;
    end
  end

  // Working registers of the sift.
  always_ff @(posedge clk_i) begin
    case (ctrl_i.op)
      mhpq_pkg::OP_ACCEPT: begin
        if (in_valid_i) begin
          req_q <= req_type_i;
          key_q <= key_value_i;
        end
      end
      mhpq_pkg::OP_INS_START: pos_q <= cnt_q[IW-1:0];
      mhpq_pkg::OP_MOVE_UP:   pos_q <= parent_idx;
      mhpq_pkg::OP_REM_START: pos_q <= '0;
      mhpq_pkg::OP_LOAD_KEY:  key_q <= rdata_q;
      mhpq_pkg::OP_TAKE_LEFT: begin
        cand_q <= rdata_q;
        cidx_q <= left_x[IW-1:0];
      end
      mhpq_pkg::OP_TAKE_RIGHT: begin
        if (rdata_q > cand_q) begin
          cand_q <= rdata_q;
          cidx_q <= right_x[IW-1:0];
        end
      end
      mhpq_pkg::OP_MOVE_DOWN: pos_q <= cidx_q;
      default: ;
    endcase
  end

  // Entry count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      case (ctrl_i.op)
        mhpq_pkg::OP_INS_START: cnt_q <= cnt_q + CW'(1);
        mhpq_pkg::OP_REM_START: cnt_q <= cnt_q - CW'(1);
        mhpq_pkg::OP_CLEAR:     cnt_q <= '0;
        default: ;
      endcase
    end
  end

  // Result status for the finishing steps.
  always_comb begin
    fin        = 1'b1;
    fin_status = mhpq_pkg::STAT_DONE;
    case (ctrl_i.op)
      mhpq_pkg::OP_FIN_DONE:  fin_status = mhpq_pkg::STAT_DONE;
      mhpq_pkg::OP_FIN_FULL:  fin_status = mhpq_pkg::STAT_FULL;
      mhpq_pkg::OP_FIN_EMPTY: fin_status = mhpq_pkg::STAT_EMPTY;
      default:                fin        = 1'b0;
    endcase
  end

  // Output register: the result waits here while the next item is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin) begin
      status_q <= fin_status;
      total_q  <= mhpq_pkg::TOTAL_W'(cnt_q);
      topv_q   <= (cnt_q != '0);
      topk_q   <= (cnt_q != '0) ? top_q : '0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign entry_total_o = total_q;
  assign top_valid_o   = topv_q;
  assign top_key_o     = topk_q;

  // Flags for the sequencer's jumps.
  assign flags_o.item_valid       = in_valid_i;
  assign flags_o.out_busy         = out_valid_q && !out_ready_i;
  assign flags_o.is_remove        = (req_q == mhpq_pkg::REQ_REMOVE);
  assign flags_o.full             = (cnt_q == CW'(mhpq_pkg::CAPACITY));
  assign flags_o.empty            = (cnt_q == '0);
  assign flags_o.one              = (cnt_q == CW'(1));
  assign flags_o.at_root          = (pos_q == '0);
  assign flags_o.parent_not_less  = !(rdata_q < key_q);
  assign flags_o.no_left          = (left_x >= XW'(cnt_q));
  assign flags_o.no_right         = (right_x >= XW'(cnt_q));
  assign flags_o.child_not_bigger = !(cand_q > key_q);

  // The count never passes the capacity.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(mhpq_pkg::CAPACITY))
    else $error("entry count above capacity");

  // Every store write lands inside the live part of the heap.
  a_write_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (CW'(pos_q) < cnt_q))
    else $error("store write outside the held entries");

  // A full report only comes from a full heap.
  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.op == mhpq_pkg::OP_FIN_FULL) |-> (cnt_q == CW'(mhpq_pkg::CAPACITY)))
    else $error("full status with room left");

  // A finishing step always presents a result on the next cycle.
  a_fin_presents: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin |=> out_valid_q)
    else $error("finished item not presented");

endmodule

// File: hw/rtl/max_heap_priority_queue.sv
// Channel  Direction  Handshake              Payload
// in       input      in_valid_i/in_ready_o   req_type_i, key_value_i
// out      output     out_valid_o/out_ready_i status_o, entry_total_o, top_valid_o,
//                                             top_key_o
//
// One item at a time runs through a microprogram, from the accepting step to the result
// step. An insert climbs while the parent key is smaller; a remove moves the last key to
// the root and sinks it toward the larger child, and taking the last key clears the count.
// At most log2(CAPACITY) levels are walked. Reset clears the count and the sequencer; the
// key store is not cleared. A stalled result holds in the output register while the next
// item is accepted and worked on; the next result step waits until it is taken.
module max_heap_priority_queue (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              req_type_i,
  input  logic signed [mhpq_pkg::KEY_W-1:0] key_value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [mhpq_pkg::STAT_W-1:0]       status_o,
  output logic [mhpq_pkg::TOTAL_W-1:0]      entry_total_o,
  output logic                              top_valid_o,
  output logic signed [mhpq_pkg::KEY_W-1:0] top_key_o
);

  mhpq_pkg::ctrl_t  ctrl;
  mhpq_pkg::flags_t flags;

  // Microprogram sequencer.
  mhpq_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .ctrl_o  (ctrl)
  );

  // Store, sift registers and output register.
  mhpq_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .flags_o       (flags),
    .in_valid_i    (in_valid_i),
    .req_type_i    (req_type_i),
    .key_value_i   (key_value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .entry_total_o (entry_total_o),
    .top_valid_o   (top_valid_o),
    .top_key_o     (top_key_o)
  );

  // The item is taken only in the idle step.
  assign in_ready_o = (ctrl.op == mhpq_pkg::OP_ACCEPT);

endmodule

// File: dv/tb_max_heap_priority_queue.sv
`timescale 1ns / 1ps

module tb_max_heap_priority_queue;

  // One request on the input channel.
  typedef struct {
    logic                              req_type;
    logic signed [mhpq_pkg::KEY_W-1:0] key;
  } heap_req_t;

  // One result as the block should report it.
  typedef struct {
    mhpq_pkg::status_e                 status;
    logic [mhpq_pkg::TOTAL_W-1:0]      total;
    logic                              top_valid;
    logic signed [mhpq_pkg::KEY_W-1:0] top_key;
  } heap_result_t;

  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_RANDOM,
    RDY_PATTERN,
    RDY_SPARSE
  } ready_mode_e;

  localparam int unsigned RANDOM_ITEMS = 1830;
  localparam int unsigned DRAIN_CYCLES = 60;

  logic                              clk_i         = 1'b0;
  logic                              rst_ni        = 1'b0;
  logic                              in_valid_i    = 1'b0;
  logic                              in_ready_o;
  logic                              req_type_i    = mhpq_pkg::REQ_INSERT;
  logic signed [mhpq_pkg::KEY_W-1:0] key_value_i   = '0;
  logic                              out_valid_o;
  logic                              out_ready_i   = 1'b0;
  logic [mhpq_pkg::STAT_W-1:0]       status_o;
  logic [mhpq_pkg::TOTAL_W-1:0]      entry_total_o;
  logic                              top_valid_o;
  logic signed [mhpq_pkg::KEY_W-1:0] top_key_o;

  heap_req_t    pending_reqs[$];
  heap_result_t expected_results[$];

  // Shadow copy of the heap, updated as each item is accepted.
  logic signed [mhpq_pkg::KEY_W-1:0] shadow_keys[mhpq_pkg::CAPACITY];
  int unsigned                       shadow_count = 0;

  int unsigned mismatch_count = 0;

  max_heap_priority_queue i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .req_type_i    (req_type_i),
    .key_value_i   (key_value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .entry_total_o (entry_total_o),
    .top_valid_o   (top_valid_o),
    .top_key_o     (top_key_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Applies one request to the shadow heap and returns the result it should give.
  function automatic heap_result_t heap_apply(heap_req_t req);
    heap_result_t                      res;
    int unsigned                       pos;
    int unsigned                       parent;
    int unsigned                       best;
    int unsigned                       lc;
    int unsigned                       rc;
    logic signed [mhpq_pkg::KEY_W-1:0] tmp;
    bit                                settled;
    res.status = mhpq_pkg::STAT_DONE;
    if (req.req_type == mhpq_pkg::REQ_INSERT) begin
      if (shadow_count >= mhpq_pkg::CAPACITY) begin
        res.status = mhpq_pkg::STAT_FULL;
      end else begin
        pos = shadow_count;
        shadow_keys[pos] = req.key;
        shadow_count++;
        // Climb while the parent is strictly smaller.
        settled = 1'b0;
        while (pos != 0 && !settled) begin
          parent = (pos - 1) / 2;
          if (shadow_keys[parent] < shadow_keys[pos]) begin
            tmp = shadow_keys[parent];
            shadow_keys[parent] = shadow_keys[pos];
            shadow_keys[pos] = tmp;
            pos = parent;
          end else begin
            settled = 1'b1;
          end
        end
      end
    end else begin
      if (shadow_count == 0) begin
        res.status = mhpq_pkg::STAT_EMPTY;
      end else if (shadow_count == 1) begin
        shadow_count = 0;
      end else begin
        shadow_keys[0] = shadow_keys[shadow_count - 1];
        shadow_count--;
        // Descend toward the larger child; the left child wins a tie.
        pos = 0;
        settled = 1'b0;
        while (!settled) begin
          best = pos;
          lc = 2 * pos + 1;
          rc = 2 * pos + 2;
          if (lc < shadow_count && shadow_keys[lc] > shadow_keys[best]) best = lc;
          if (rc < shadow_count && shadow_keys[rc] > shadow_keys[best]) best = rc;
          if (best == pos) begin
            settled = 1'b1;
          end else begin
            tmp = shadow_keys[pos];
            shadow_keys[pos] = shadow_keys[best];
            shadow_keys[best] = tmp;
            pos = best;
          end
        end
      end
    end
    res.total     = mhpq_pkg::TOTAL_W'(shadow_count);
    res.top_valid = (shadow_count > 0);
    res.top_key   = (shadow_count > 0) ? shadow_keys[0] : '0;
    return res;
  endfunction

  // Key picker: full range, a narrow band that makes ties, the extremes and a band around zero.
  function automatic logic signed [mhpq_pkg::KEY_W-1:0] pick_key();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return $urandom;
    if (sel < 7) return $signed(mhpq_pkg::KEY_W'($urandom_range(0, 8))) - 4;
    if (sel == 7) begin
      case ($urandom_range(0, 3))
        0:       return 32'sh7FFF_FFFF;
        1:       return 32'sh8000_0000;
        2:       return '0;
        default: return -1;
      endcase
    end
    return $signed(mhpq_pkg::KEY_W'($urandom_range(0, 2000))) - 1000;
  endfunction

  function automatic heap_req_t make_req(logic req_type,
                                         logic signed [mhpq_pkg::KEY_W-1:0] key);
    heap_req_t r;
    r.req_type = req_type;
    r.key      = key;
    return r;
  endfunction

  // Sender: items go out in bursts of random length separated by random gaps.
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(posedge clk_i) begin
    heap_req_t nxt;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        expected_results.push_back(heap_apply(make_req(req_type_i, key_value_i)));
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          nxt = pending_reqs.pop_front();
          in_valid_i  <= 1'b1;
          req_type_i  <= nxt.req_type;
          key_value_i <= nxt.key;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            case ($urandom_range(0, 3))
              0:       gap_left = 0;
              1:       gap_left = $urandom_range(1, 3);
              2:       gap_left = $urandom_range(4, 12);
              default: gap_left = $urandom_range(13, 40);
            endcase
          end else begin
            burst_left--;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall behaviour changes from one stretch of cycles to the next.
  ready_mode_e ready_mode    = RDY_ALWAYS;
  int unsigned mode_left     = 0;
  logic [15:0] stall_pattern = 16'hFFFF;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (mode_left == 0) begin
        mode_left  = $urandom_range(40, 300);
        ready_mode = ready_mode_e'($urandom_range(0, 3));
        stall_pattern <= 16'($urandom);
      end else begin
        mode_left--;
        stall_pattern <= {stall_pattern[14:0], stall_pattern[15]};
      end
      case (ready_mode)
        RDY_ALWAYS:  out_ready_i <= 1'b1;
        RDY_RANDOM:  out_ready_i <= 1'($urandom_range(0, 1));
        RDY_PATTERN: out_ready_i <= stall_pattern[15];
        default:     out_ready_i <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Result checker: each accepted result against the oldest expectation.
  always @(posedge clk_i) begin
    heap_result_t exp_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: status %0d total %0d top_valid %0b top_key %0d",
                   status_o, entry_total_o, top_valid_o, top_key_o);
      end else begin
        exp_res = expected_results.pop_front();
        if (status_o !== exp_res.status || entry_total_o !== exp_res.total ||
            top_valid_o !== exp_res.top_valid || top_key_o !== exp_res.top_key) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"mismatch: expected status %0d total %0d top_valid %0b ",
                      "top_key %0d, got status %0d total %0d top_valid %0b top_key %0d"},
                     exp_res.status, exp_res.total, exp_res.top_valid, exp_res.top_key,
                     status_o, entry_total_o, top_valid_o, top_key_o);
        end
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int unsigned insert_pct;
    int unsigned phase_left;
    int unsigned k;
    // Directed: removes on an empty heap, removal of the last key, extreme keys,
    // ties, filling to capacity and an insert into a full heap.
    pending_reqs.push_back(make_req(mhpq_pkg::REQ_REMOVE, 32'sh1234_5678));
    pending_reqs.push_back(make_req(mhpq_pkg::REQ_INSERT, 32'sh7FFF_FFFF));
    pending_reqs.push_back(make_req(mhpq_pkg::REQ_REMOVE, '0));
    pending_reqs.push_back(make_req(mhpq_pkg::REQ_REMOVE, -1));
    pending_reqs.push_back(make_req(mhpq_pkg::REQ_INSERT, 32'sh8000_0000));
    pending_reqs.push_back(make_req(mhpq_pkg::REQ_INSERT, 32'sh7FFF_FFFF));
    pending_reqs.push_back(make_req(mhpq_pkg::REQ_INSERT, '0));
    pending_reqs.push_back(make_req(mhpq_pkg::REQ_INSERT, -1));
    pending_reqs.push_back(make_req(mhpq_pkg::REQ_INSERT, 1));
    for (k = 0; k < 6; k++) pending_reqs.push_back(make_req(mhpq_pkg::REQ_INSERT, 5));
    pending_reqs.push_back(make_req(mhpq_pkg::REQ_INSERT, 32'sh7FFF_FFFF));
    pending_reqs.push_back(make_req(mhpq_pkg::REQ_INSERT, 32'sh8000_0000));
    pending_reqs.push_back(make_req(mhpq_pkg::REQ_INSERT, 32'sh5555_5555));
    pending_reqs.push_back(make_req(mhpq_pkg::REQ_INSERT, 32'shAAAA_AAAA));
    pending_reqs.push_back(make_req(mhpq_pkg::REQ_INSERT, 7));
    pending_reqs.push_back(make_req(mhpq_pkg::REQ_INSERT, 32'sh7FFF_FFFF));
    pending_reqs.push_back(make_req(mhpq_pkg::REQ_REMOVE, '0));
    pending_reqs.push_back(make_req(mhpq_pkg::REQ_REMOVE, '0));
    pending_reqs.push_back(make_req(mhpq_pkg::REQ_REMOVE, '0));

    // Random: phases that lean towards filling, draining or holding steady,
    // so the count sweeps between empty and full.
    phase_left = 0;
    insert_pct = 50;
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(10, 60);
        case ($urandom_range(0, 2))
          0:       insert_pct = 80;
          1:       insert_pct = 25;
          default: insert_pct = 50;
        endcase
      end
      phase_left--;
      if ($urandom_range(0, 99) < insert_pct)
        pending_reqs.push_back(make_req(mhpq_pkg::REQ_INSERT, pick_key()));
      else
        pending_reqs.push_back(make_req(mhpq_pkg::REQ_REMOVE, 32'($urandom)));
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_reqs.size() > 0 || in_valid_i || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("tb_max_heap_priority_queue: clean");
    end else begin
      $display("tb_max_heap_priority_queue: errors");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("tb_max_heap_priority_queue: errors");
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/mhpq_pkg.sv
hw/rtl/mhpq_seq.sv
hw/rtl/mhpq_dp.sv
hw/rtl/max_heap_priority_queue.sv
dv/tb_max_heap_priority_queue.sv
